// ===== rtl/core/modexp_pkg.sv =====
package modexp_pkg;

  // prime modulus and field widths
  localparam int unsigned ValW    = 30;
  localparam int unsigned ExpW    = 32;
  localparam int unsigned MulW    = 31;
  localparam int unsigned ProdW   = 2 * MulW;
  localparam logic [ValW-1:0] Modulus = 30'd998244353;

  // number of exponent bits walked, msb first
  localparam int unsigned ExpBits = 32;
  localparam int unsigned CntW    = $clog2(ExpBits + 1);

  // barrett constant floor(2^60 / modulus), fits in 31 bits
  localparam logic [63:0]     BarrettFull = 64'h1000_0000_0000_0000 / 64'(Modulus);
  localparam logic [MulW-1:0] BarrettM    = MulW'(BarrettFull);

  // sequencer states, one modular multiply takes ST_MUL .. ST_SUB
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_LO,
    ST_HI,
    ST_QUO,
    ST_QM,
    ST_SUB
  } modexp_state_e;

endpackage

// ===== rtl/core/modexp_mul.sv =====
module modexp_mul
  import modexp_pkg::*;
(
  input  logic             clk_i,
  input  logic [MulW-1:0]  op_a_i,
  input  logic [MulW-1:0]  op_b_i,
  output logic [ProdW-1:0] prod_o
);

  logic [ProdW-1:0] prod_d;
  logic [ProdW-1:0] prod_q;

  // shared unsigned multiplier, product registered
  assign prod_d = {{(ProdW-MulW){1'b0}}, op_a_i} * {{(ProdW-MulW){1'b0}}, op_b_i};

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
  end

  assign prod_o = prod_q;

endmodule

// ===== rtl/core/modular_exponentiation_core.sv =====
// channel  | strobe / accept      | fields
// ---------+----------------------+---------------------------------------
// input    | start & !busy        | base_i [29:0], exponent_i [31:0]
// result   | done_o (one cycle)   | power_mod_o [29:0]
//
// one shared 31x31 multiplier does every product; a modular multiply walks the
// steps product, two barrett quotient products, quotient add, q*M and subtract.
// each exponent bit costs a square plus a multiply when the bit is set.
// busy stays high for the whole item; done_o rises at the edge that drops busy.
// async active-low reset clears the sequencer only; the receiver cannot stall.
module modular_exponentiation_core
  import modexp_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start,
  output logic            busy,
  input  logic [ValW-1:0] base_i,
  input  logic [ExpW-1:0] exponent_i,
  output logic            done_o,
  output logic [ValW-1:0] power_mod_o
);

  modexp_state_e state_d, state_q;
  logic               mult_d, mult_q;
  logic [CntW-1:0]    cnt_d, cnt_q;
  logic               done_d, done_q;

  logic [ValW-1:0]    acc_d, acc_q;
  logic [ValW-1:0]    base_d, base_q;
  logic [ExpBits-1:0] e_d, e_q;
  logic [59:0]        p_d, p_q;
  logic [MulW-1:0]    t_d, t_q;
  logic [ValW-1:0]    q_d, q_q;
  logic [ValW-1:0]    res_d, res_q;

  logic [MulW-1:0]    op_a, op_b;
  logic [ProdW-1:0]   prod;
  logic [ProdW-1:0]   quo_sum;
  logic [MulW-1:0]    rem_raw;
  logic [MulW-1:0]    rem_fix;
  logic [ValW-1:0]    base_red;

  modexp_mul u_mul (
    .clk_i  (clk_i),
    .op_a_i (op_a),
    .op_b_i (op_b),
    .prod_o (prod)
  );

  // base may lie up to one modulus too high
  assign base_red = (base_i >= Modulus) ? (base_i - Modulus) : base_i;

  // barrett quotient: (hi*m + (lo*m >> 30)) >> 30
  assign quo_sum = {1'b0, prod[60:0]} + ProdW'(t_q);

  // remainder below 2M, so 31 bits suffice, then one correction
  assign rem_raw = p_q[MulW-1:0] - prod[MulW-1:0];
  assign rem_fix = (rem_raw >= MulW'(Modulus)) ? (rem_raw - MulW'(Modulus)) : rem_raw;

  // sequencer state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      mult_q  <= 1'b0;
      cnt_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      mult_q  <= mult_d;
      cnt_q   <= cnt_d;
      done_q  <= done_d;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    acc_q  <= acc_d;
    base_q <= base_d;
    e_q    <= e_d;
    p_q    <= p_d;
    t_q    <= t_d;
    q_q    <= q_d;
    res_q  <= res_d;
  end

  // next state, multiplier operands and datapath updates
  always_comb begin
    state_d = state_q;
    mult_d  = mult_q;
    cnt_d   = cnt_q;
    done_d  = 1'b0;
    acc_d   = acc_q;
    base_d  = base_q;
    e_d     = e_q;
    p_d     = p_q;
    t_d     = t_q;
    q_d     = q_q;
    res_d   = res_q;
    op_a    = '0;
    op_b    = '0;

    unique case (state_q)
      ST_IDLE: begin
        if (start) begin
          acc_d   = ValW'(1);
          base_d  = base_red;
          e_d     = ExpBits'(exponent_i);
          cnt_d   = CntW'(ExpBits);
          mult_d  = 1'b0;
          state_d = ST_MUL;
        end
      end
      ST_MUL: begin
        op_a    = MulW'(acc_q);
        op_b    = mult_q ? MulW'(base_q) : MulW'(acc_q);
        state_d = ST_LO;
      end
      ST_LO: begin
        p_d     = prod[59:0];
        op_a    = MulW'(prod[29:0]);
        op_b    = BarrettM;
        state_d = ST_HI;
      end
      ST_HI: begin
        t_d     = prod[60:30];
        op_a    = MulW'(p_q[59:30]);
        op_b    = BarrettM;
        state_d = ST_QUO;
      end
      ST_QUO: begin
        q_d     = quo_sum[59:30];
        state_d = ST_QM;
      end
      ST_QM: begin
        op_a    = MulW'(q_q);
        op_b    = MulW'(Modulus);
        state_d = ST_SUB;
      end
      ST_SUB: begin
        acc_d = rem_fix[ValW-1:0];
        if (!mult_q && e_q[ExpBits-1]) begin
          mult_d  = 1'b1;
          state_d = ST_MUL;
        end else begin
          mult_d = 1'b0;
          e_d    = e_q << 1;
          cnt_d  = cnt_q - CntW'(1);
          if (cnt_q == CntW'(1)) begin
            res_d   = rem_fix[ValW-1:0];
            done_d  = 1'b1;
            state_d = ST_IDLE;
          end else begin
            state_d = ST_MUL;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign busy        = (state_q != ST_IDLE);
  assign done_o      = done_q;
  assign power_mod_o = res_q;

endmodule
